/* rtl/rlm_pkg.sv */
package rlm_pkg;

  localparam int TARGET_W = 40;
  localparam int T10_W    = 44;
  localparam int T100_W   = 47;
  localparam int PPS_W    = 20;
  localparam int CNT_W    = 64;
  localparam int BYTES_W  = 32;
  localparam int WAIT_W   = 48;
  localparam int CFG_IDX_W = 1;
  localparam int NUM_BINS = 8;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PPS    = 1'b1;

  localparam logic [TARGET_W-1:0] TARGET_RST = 40'd1000000;
  localparam logic [T10_W-1:0]    T10_RST    = 44'd10000000;
  localparam logic [T100_W-1:0]   T100_RST   = 47'd100000000;
  localparam logic [PPS_W-1:0]    PPS_RST    = 20'd1;

  localparam logic [1:0] BIN_MET     = 2'd0;
  localparam logic [1:0] BIN_MISS    = 2'd1;
  localparam logic [1:0] BIN_MISS10  = 2'd2;
  localparam logic [1:0] BIN_MISS100 = 2'd3;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_END   = 2'd1,
    ACT_TICK  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    RUN_IDLE     = 3'b001,
    RUN_RUNNING  = 3'b010,
    RUN_DANGLING = 3'b100
  } run_e;

  typedef enum logic [4:0] {
    BK_POP  = 5'b00001,
    BK_FOLD = 5'b00010,
    BK_MLO  = 5'b00100,
    BK_MHI  = 5'b01000,
    BK_EMIT = 5'b10000
  } back_e;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [TARGET_W-1:0]  data;
  } cfg_wr_t;

  // queued operation: completed IO or an emitting tick
  typedef struct packed {
    logic               is_tick;
    logic               dir;
    logic [BYTES_W-1:0] bytes;
    logic [1:0]         bin;
  } q_entry_t;

endpackage

/* rtl/rlm_if.sv */
interface rlm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic        direction;
  logic [31:0] byte_count;
  logic [47:0] wait_time;

  modport source(output valid, action, direction, byte_count, wait_time, input ready);
  modport sink(input valid, action, direction, byte_count, wait_time, output ready);
endinterface

interface rlm_out_if;
  logic        valid;
  logic        ready;
  logic        out_direction;
  logic [63:0] bytes_per_second;
  logic [63:0] ops_per_second;
  logic [63:0] latency_met;
  logic [63:0] latency_missed;
  logic [63:0] latency_missed_ten;
  logic [63:0] latency_missed_hundred;
  logic        last;

  modport source(output valid, out_direction, bytes_per_second, ops_per_second, latency_met,
                 latency_missed, latency_missed_ten, latency_missed_hundred, last,
                 input ready);
  modport sink(input valid, out_direction, bytes_per_second, ops_per_second, latency_met,
               latency_missed, latency_missed_ten, latency_missed_hundred, last,
               output ready);
endinterface

/* rtl/rlm_front.sv */
module rlm_front #(
  parameter int OUTSTANDING_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rlm_pkg::cfg_wr_t    cfg_i,
  rlm_in_if.sink              in_i,
  input  logic                q_full_i,
  output logic                push_o,
  output rlm_pkg::q_entry_t   entry_o
);

  logic [rlm_pkg::TARGET_W-1:0] target_q;
  logic [rlm_pkg::T10_W-1:0]    t10_q, t10_d;
  logic [rlm_pkg::T100_W-1:0]   t100_q, t100_d;
  logic [OUTSTANDING_BITS-1:0]  outst_q, outst_d;
  rlm_pkg::run_e                run_q, run_d;
  logic                         accept;
  logic                         emit;
  logic                         is_end;
  logic                         is_tick;
  logic [1:0]                   bin;

  assign in_i.ready = ~q_full_i;
  assign accept     = in_i.valid & in_i.ready;

  assign t10_d  = ({4'b0, cfg_i.data} << 3) + ({4'b0, cfg_i.data} << 1);
  assign t100_d = ({7'b0, cfg_i.data} << 6) + ({7'b0, cfg_i.data} << 5) +
                  ({7'b0, cfg_i.data} << 2);

  always_comb begin
    if (in_i.wait_time <= {8'b0, target_q}) begin
      bin = rlm_pkg::BIN_MET;
    end else if (in_i.wait_time <= {4'b0, t10_q}) begin
      bin = rlm_pkg::BIN_MISS;
    end else if (in_i.wait_time <= {1'b0, t100_q}) begin
      bin = rlm_pkg::BIN_MISS10;
    end else begin
      bin = rlm_pkg::BIN_MISS100;
    end
  end

  always_comb begin
    outst_d = outst_q;
    run_d   = run_q;
    emit    = 1'b0;
    is_end  = 1'b0;
    is_tick = 1'b0;
    unique case (rlm_pkg::action_e'(in_i.action))
      rlm_pkg::ACT_START: begin
        if (outst_q != '1) outst_d = outst_q + 1'b1;
        if (run_q == rlm_pkg::RUN_IDLE) run_d = rlm_pkg::RUN_RUNNING;
      end
      rlm_pkg::ACT_END: begin
        is_end = 1'b1;
        if (outst_q != '0) outst_d = outst_q - 1'b1;
      end
      rlm_pkg::ACT_TICK: begin
        is_tick = 1'b1;
        unique case (run_q)
          rlm_pkg::RUN_RUNNING: begin
            emit = 1'b1;
            if (outst_q == '0) run_d = rlm_pkg::RUN_DANGLING;
          end
          rlm_pkg::RUN_DANGLING: begin
            emit  = 1'b1;
            run_d = (outst_q != '0) ? rlm_pkg::RUN_RUNNING : rlm_pkg::RUN_IDLE;
          end
          default: run_d = rlm_pkg::RUN_IDLE;
        endcase
      end
      default: ;
    endcase
  end

  assign push_o          = accept & (is_end | emit);
  assign entry_o.is_tick = is_tick;
  assign entry_o.dir     = in_i.direction;
  assign entry_o.bytes   = in_i.byte_count;
  assign entry_o.bin     = bin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= rlm_pkg::TARGET_RST;
      t10_q    <= rlm_pkg::T10_RST;
      t100_q   <= rlm_pkg::T100_RST;
      outst_q  <= '0;
      run_q    <= rlm_pkg::RUN_IDLE;
    end else begin
      if (cfg_i.we && cfg_i.idx == rlm_pkg::REG_TARGET) begin
        target_q <= cfg_i.data;
        t10_q    <= t10_d;
        t100_q   <= t100_d;
      end
      if (accept) begin
        outst_q <= outst_d;
        run_q   <= run_d;
      end
    end
  end

endmodule

/* rtl/rlm_queue.sv */
module rlm_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rlm_pkg::q_entry_t entry_i,
  input  logic              pop_i,
  output rlm_pkg::q_entry_t head_o,
  output logic              full_o,
  output logic              empty_o
);

  rlm_pkg::q_entry_t            mem_q [rlm_pkg::Q_DEPTH];
  logic [rlm_pkg::Q_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [rlm_pkg::Q_PTR_W:0]    cnt_q;

  assign full_o  = cnt_q == (rlm_pkg::Q_PTR_W+1)'(rlm_pkg::Q_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o)) else $error("queue pop while empty");

endmodule

/* rtl/rlm_back.sv */
module rlm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rlm_pkg::cfg_wr_t  cfg_i,
  input  rlm_pkg::q_entry_t head_i,
  input  logic              empty_i,
  output logic              pop_o,
  rlm_out_if.source         out_o
);

  localparam int PROD_W = rlm_pkg::BYTES_W + rlm_pkg::PPS_W;

  rlm_pkg::back_e               state_q, state_d;
  logic [rlm_pkg::PPS_W-1:0]    pps_q;
  logic [rlm_pkg::CNT_W-1:0]    per_ops_q   [2];
  logic [rlm_pkg::CNT_W-1:0]    per_bytes_q [2];
  logic [rlm_pkg::CNT_W-1:0]    per_lat_q   [rlm_pkg::NUM_BINS];
  logic [rlm_pkg::CNT_W-1:0]    tot_q       [rlm_pkg::NUM_BINS];
  logic [rlm_pkg::CNT_W:0]      fold_sum    [rlm_pkg::NUM_BINS];
  logic                         wraps;
  logic                         dir_q;
  logic [PROD_W-1:0]            pl_b_q, pl_o_q;
  logic [31:0]                  ph_b_q, ph_o_q;
  logic [31:0]                  mul_b_src, mul_o_src;
  logic [PROD_W-1:0]            prod_b, prod_o;
  logic                         end_apply;
  logic [2:0]                   lat_idx;
  logic                         out_free;
  logic                         out_load;
  logic                         tick_done;

  logic                         out_valid_q;
  logic                         out_dir_q;
  logic [rlm_pkg::CNT_W-1:0]    out_bps_q, out_ops_q;
  logic [rlm_pkg::CNT_W-1:0]    out_met_q, out_miss_q, out_miss10_q, out_miss100_q;

  assign pop_o     = (state_q == rlm_pkg::BK_POP) && !empty_i;
  assign end_apply = pop_o && !head_i.is_tick;
  assign lat_idx   = {head_i.dir, head_i.bin};
  assign out_free  = !out_valid_q || out_o.ready;
  assign out_load  = (state_q == rlm_pkg::BK_EMIT) && out_free;
  assign tick_done = out_load && dir_q;

  always_comb begin
    wraps = 1'b0;
    for (int i = 0; i < rlm_pkg::NUM_BINS; i++) begin
      fold_sum[i] = {1'b0, tot_q[i]} + {1'b0, per_lat_q[i]};
      wraps       = wraps | fold_sum[i][rlm_pkg::CNT_W];
    end
  end

  // 64 x 20 rate product as two 32 x 20 halves; the high half only matters mod 2^32
  assign mul_b_src = (state_q == rlm_pkg::BK_MLO) ? per_bytes_q[dir_q][31:0]
                                                  : per_bytes_q[dir_q][63:32];
  assign mul_o_src = (state_q == rlm_pkg::BK_MLO) ? per_ops_q[dir_q][31:0]
                                                  : per_ops_q[dir_q][63:32];
  assign prod_b = PROD_W'(mul_b_src) * PROD_W'(pps_q);
  assign prod_o = PROD_W'(mul_o_src) * PROD_W'(pps_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rlm_pkg::BK_POP:  if (pop_o && head_i.is_tick) state_d = rlm_pkg::BK_FOLD;
      rlm_pkg::BK_FOLD: state_d = rlm_pkg::BK_MLO;
      rlm_pkg::BK_MLO:  state_d = rlm_pkg::BK_MHI;
      rlm_pkg::BK_MHI:  state_d = rlm_pkg::BK_EMIT;
      rlm_pkg::BK_EMIT: begin
        if (out_load) state_d = dir_q ? rlm_pkg::BK_POP : rlm_pkg::BK_MLO;
      end
      default: state_d = rlm_pkg::BK_POP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rlm_pkg::BK_POP;
      pps_q       <= rlm_pkg::PPS_RST;
      dir_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        per_ops_q[i]   <= '0;
        per_bytes_q[i] <= '0;
      end
      for (int i = 0; i < rlm_pkg::NUM_BINS; i++) begin
        per_lat_q[i] <= '0;
        tot_q[i]     <= '0;
      end
    end else begin
      state_q <= state_d;

      if (cfg_i.we && cfg_i.idx == rlm_pkg::REG_PPS) begin
        pps_q <= cfg_i.data[rlm_pkg::PPS_W-1:0];
      end

      for (int i = 0; i < 2; i++) begin
        if (end_apply && head_i.dir == 1'(i)) begin
          per_ops_q[i]   <= per_ops_q[i] + 64'd1;
          per_bytes_q[i] <= per_bytes_q[i] + {32'b0, head_i.bytes};
        end else if (tick_done) begin
          per_ops_q[i]   <= '0;
          per_bytes_q[i] <= '0;
        end
      end

      for (int i = 0; i < rlm_pkg::NUM_BINS; i++) begin
        if (end_apply && lat_idx == 3'(i)) begin
          per_lat_q[i] <= per_lat_q[i] + 64'd1;
        end else if (tick_done) begin
          per_lat_q[i] <= '0;
        end
        if (cfg_i.we && cfg_i.idx == rlm_pkg::REG_TARGET) begin
          tot_q[i] <= '0;
        end else if (state_q == rlm_pkg::BK_FOLD) begin
          tot_q[i] <= wraps ? per_lat_q[i] : fold_sum[i][rlm_pkg::CNT_W-1:0];
        end
      end

      if (state_q == rlm_pkg::BK_FOLD) begin
        dir_q <= 1'b0;
      end else if (out_load) begin
        dir_q <= ~dir_q;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == rlm_pkg::BK_MLO) begin
      pl_b_q <= prod_b;
      pl_o_q <= prod_o;
    end
    if (state_q == rlm_pkg::BK_MHI) begin
      ph_b_q <= prod_b[31:0];
      ph_o_q <= prod_o[31:0];
    end
    if (out_load) begin
      out_dir_q     <= dir_q;
      out_bps_q     <= {12'b0, pl_b_q} + {ph_b_q, 32'b0};
      out_ops_q     <= {12'b0, pl_o_q} + {ph_o_q, 32'b0};
      out_met_q     <= tot_q[{dir_q, rlm_pkg::BIN_MET}];
      out_miss_q    <= tot_q[{dir_q, rlm_pkg::BIN_MISS}];
      out_miss10_q  <= tot_q[{dir_q, rlm_pkg::BIN_MISS10}];
      out_miss100_q <= tot_q[{dir_q, rlm_pkg::BIN_MISS100}];
    end
  end

  assign out_o.valid                  = out_valid_q;
  assign out_o.out_direction          = out_dir_q;
  assign out_o.bytes_per_second       = out_bps_q;
  assign out_o.ops_per_second         = out_ops_q;
  assign out_o.latency_met            = out_met_q;
  assign out_o.latency_missed         = out_miss_q;
  assign out_o.latency_missed_ten     = out_miss10_q;
  assign out_o.latency_missed_hundred = out_miss100_q;
  assign out_o.last                   = out_dir_q;

  a_fold_then_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rlm_pkg::BK_FOLD |=> state_q == rlm_pkg::BK_MLO && !dir_q)
    else $error("fold not followed by read-side multiply");

  a_period_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_done |=> per_ops_q[0] == '0 && per_ops_q[1] == '0 && per_bytes_q[0] == '0)
    else $error("period counters not cleared after tick");

  a_end_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rlm_pkg::BK_POP && !(pop_o && head_i.is_tick) |=> state_q == rlm_pkg::BK_POP)
    else $error("sequencer left pop state without a tick");

  a_read_before_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && dir_q |-> $past(state_q) == rlm_pkg::BK_MHI || $past(state_q) == rlm_pkg::BK_EMIT)
    else $error("write result loaded out of sequence");

endmodule

/* rtl/io_rate_and_latency_monitor_unit.sv */
// channel | dir | handshake     | payload
// in_i    | in  | valid/ready   | action, direction, byte_count, wait_time
// out_o   | out | valid/ready   | out_direction, rates, four latency bins, last
// cfg     | in  | cfg_we_i      | cfg_idx_i (0 target, 1 periods/s), cfg_data_i
//
// Start and end items are taken one per cycle while the queue is not full; an end reaches
// the period counters at the edge it leaves the 4-entry queue.
// A tick that emits holds the back end for 1 fold, then per direction a low and a
// high 32x20 multiply and one output load, which waits while out_o stalls;
// the queue keeps taking items until it holds 4.
// Reset clears all counters and state at once; no clearing pass.
// A stalled output holds only the back end; the front keeps filling the queue.
module io_rate_and_latency_monitor_unit #(
  parameter int OUTSTANDING_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rlm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rlm_pkg::TARGET_W-1:0]      cfg_data_i,
  rlm_in_if.sink                            in_i,
  rlm_out_if.source                         out_o
);

  rlm_pkg::cfg_wr_t  cfg;
  rlm_pkg::q_entry_t push_entry, head;
  logic              push, pop, q_full, q_empty;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  rlm_front #(
    .OUTSTANDING_BITS(OUTSTANDING_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  rlm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  rlm_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .head_i  (head),
    .empty_i (q_empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

/* verif/tb_io_rate_and_latency_monitor_unit.sv */
`timescale 1ns / 1ps

module tb_io_rate_and_latency_monitor_unit;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [47:0] WAIT_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [39:0] TARGET_MAX = 40'hFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  action;
    logic        direction;
    logic [31:0] byte_count;
    logic [47:0] wait_time;
  } io_item_t;

  typedef struct packed {
    logic        dir;
    logic [63:0] bps;
    logic [63:0] ops;
    logic [63:0] met;
    logic [63:0] missed;
    logic [63:0] missed10;
    logic [63:0] missed100;
    logic        last;
  } report_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [rlm_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [rlm_pkg::TARGET_W-1:0]  cfg_data_i;

  rlm_in_if  io_in ();
  rlm_out_if io_rep ();

  io_rate_and_latency_monitor_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (io_in),
    .out_o      (io_rep)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow of the block's configuration and state
  logic [rlm_pkg::TARGET_W-1:0] shadow_target;
  logic [rlm_pkg::PPS_W-1:0]    pps;
  rlm_pkg::run_e                track_state;
  logic [31:0]                  in_flight;
  logic [63:0]                  per_ops [2];
  logic [63:0]                  per_bytes [2];
  logic [63:0]                  per_bins [rlm_pkg::NUM_BINS];
  logic [63:0]                  hist [rlm_pkg::NUM_BINS];

  io_item_t pending_io_items [$];
  report_t  expected_reports [$];
  int       mismatches = 0;
  int       cycle_count = 0;

  function automatic logic [1:0] latency_bin(logic [47:0] wait_ns);
    logic [63:0] t;
    t = 64'(shadow_target);
    if (wait_ns <= t) return rlm_pkg::BIN_MET;
    if (wait_ns <= t * 10) return rlm_pkg::BIN_MISS;
    if (wait_ns <= t * 100) return rlm_pkg::BIN_MISS10;
    return rlm_pkg::BIN_MISS100;
  endfunction

  task automatic account_io_item(io_item_t it);
    logic        wraps;
    logic [64:0] sum;
    logic [63:0] rate;
    report_t     rep;
    case (it.action)
      rlm_pkg::ACT_START: begin
        if (in_flight != '1) in_flight++;
        if (track_state == rlm_pkg::RUN_IDLE) track_state = rlm_pkg::RUN_RUNNING;
      end
      rlm_pkg::ACT_END: begin
        if (in_flight != '0) in_flight--;
        per_ops[it.direction] += 64'd1;
        per_bytes[it.direction] += 64'(it.byte_count);
        per_bins[{it.direction, latency_bin(it.wait_time)}] += 64'd1;
      end
      rlm_pkg::ACT_TICK: begin
        if (track_state != rlm_pkg::RUN_RUNNING && track_state != rlm_pkg::RUN_DANGLING) begin
          track_state = rlm_pkg::RUN_IDLE;
        end else begin
          // any wrapping bin restarts the whole histogram from the period
          wraps = 1'b0;
          for (int i = 0; i < rlm_pkg::NUM_BINS; i++) begin
            sum = {1'b0, hist[i]} + {1'b0, per_bins[i]};
            if (sum[64]) wraps = 1'b1;
          end
          for (int i = 0; i < rlm_pkg::NUM_BINS; i++)
            hist[i] = wraps ? per_bins[i] : hist[i] + per_bins[i];
          rate = 64'(pps);
          for (int d = 0; d < 2; d++) begin
            rep.dir       = d[0];
            rep.bps       = per_bytes[d] * rate;
            rep.ops       = per_ops[d] * rate;
            rep.met       = hist[d*4 + rlm_pkg::BIN_MET];
            rep.missed    = hist[d*4 + rlm_pkg::BIN_MISS];
            rep.missed10  = hist[d*4 + rlm_pkg::BIN_MISS10];
            rep.missed100 = hist[d*4 + rlm_pkg::BIN_MISS100];
            rep.last      = (d == 1);
            expected_reports.push_back(rep);
          end
          foreach (per_ops[i]) per_ops[i] = '0;
          foreach (per_bytes[i]) per_bytes[i] = '0;
          foreach (per_bins[i]) per_bins[i] = '0;
          if (track_state == rlm_pkg::RUN_RUNNING) begin
            if (in_flight == '0) track_state = rlm_pkg::RUN_DANGLING;
          end else begin
            track_state = (in_flight != '0) ? rlm_pkg::RUN_RUNNING : rlm_pkg::RUN_IDLE;
          end
        end
      end
      default: ;
    endcase
  endtask

  // driver: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin : in_drive
    logic accepted;
    if (!rst_ni) begin
      io_in.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      accepted = io_in.valid && io_in.ready;
      if (accepted) begin
        account_io_item(pending_io_items.pop_front());
        burst_left--;
      end
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (io_in.valid && !accepted) begin
        // hold the current item until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        io_in.valid <= 1'b0;
      end else if (pending_io_items.size() != 0) begin
        io_in.valid      <= 1'b1;
        io_in.action     <= pending_io_items[0].action;
        io_in.direction  <= pending_io_items[0].direction;
        io_in.byte_count <= pending_io_items[0].byte_count;
        io_in.wait_time  <= pending_io_items[0].wait_time;
      end else begin
        io_in.valid <= 1'b0;
      end
    end
  end

  // receiver stall: a rotating pattern, replaced now and then
  logic [7:0] stall_pat;
  int         pat_age;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      io_rep.ready <= 1'b0;
      stall_pat = 8'hFF;
      pat_age = 0;
    end else begin
      if (pat_age == 0) begin
        case ($urandom_range(0, 4))
          0, 1: stall_pat = 8'hFF;
          2: stall_pat = 8'($urandom);
          3: stall_pat = 8'h81;
          default: stall_pat = 8'h01;
        endcase
        pat_age = $urandom_range(8, 64);
      end else begin
        pat_age--;
      end
      stall_pat = {stall_pat[6:0], stall_pat[7]};
      io_rep.ready <= stall_pat[0];
    end
  end

  function automatic void check_field(string name, logic dir, logic [63:0] want,
                                      logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch dir %0d %s: expected %0h, got %0h", dir, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : rep_check
    report_t want;
    if (rst_ni && io_rep.valid && io_rep.ready) begin
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected report transfer, dir %0d", io_rep.out_direction);
      end else begin
        want = expected_reports.pop_front();
        check_field("out_direction", want.dir, 64'(want.dir), 64'(io_rep.out_direction));
        check_field("bytes_per_second", want.dir, want.bps, io_rep.bytes_per_second);
        check_field("ops_per_second", want.dir, want.ops, io_rep.ops_per_second);
        check_field("latency_met", want.dir, want.met, io_rep.latency_met);
        check_field("latency_missed", want.dir, want.missed, io_rep.latency_missed);
        check_field("latency_missed_ten", want.dir, want.missed10,
                    io_rep.latency_missed_ten);
        check_field("latency_missed_hundred", want.dir, want.missed100,
                    io_rep.latency_missed_hundred);
        check_field("last", want.dir, 64'(want.last), 64'(io_rep.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL io_rate_and_latency_monitor_unit");
      $finish;
    end
  end

  task automatic push_item(logic [1:0] action, logic dir, logic [31:0] nbytes,
                           logic [47:0] wait_ns);
    io_item_t it;
    it.action     = action;
    it.direction  = dir;
    it.byte_count = nbytes;
    it.wait_time  = wait_ns;
    pending_io_items.push_back(it);
  endtask

  // latencies clustered on the bin edges of the current target
  function automatic logic [47:0] pick_wait();
    logic [63:0] t;
    logic [63:0] w;
    t = 64'(shadow_target);
    case ($urandom_range(0, 9))
      0: w = t;
      1: w = t + 1;
      2: w = t * 10;
      3: w = t * 10 + 1;
      4: w = t * 100;
      5: w = t * 100 + 1;
      6, 7: w = {$urandom, $urandom} % (t * 100 + 2);
      8: w = 64'(WAIT_MAX);
      default: w = {$urandom, $urandom};
    endcase
    return w[47:0];
  endfunction

  task automatic push_random_item();
    int          pick;
    logic [31:0] nbytes;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: nbytes = '0;
      1: nbytes = '1;
      default: nbytes = $urandom;
    endcase
    if (pick < 38)
      push_item(rlm_pkg::ACT_START, 1'($urandom), $urandom, 48'({$urandom, $urandom}));
    else if (pick < 82)
      push_item(rlm_pkg::ACT_END, 1'($urandom), nbytes, pick_wait());
    else if (pick < 96)
      push_item(rlm_pkg::ACT_TICK, 1'($urandom), $urandom, 48'({$urandom, $urandom}));
    else
      push_item(ACT_UNUSED, 1'($urandom), $urandom, 48'({$urandom, $urandom}));
  endtask

  task automatic write_reg(logic [rlm_pkg::CFG_IDX_W-1:0] idx,
                           logic [rlm_pkg::TARGET_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == rlm_pkg::REG_TARGET) begin
      shadow_target = data;
      foreach (hist[i]) hist[i] = '0;
    end else begin
      pps = data[rlm_pkg::PPS_W-1:0];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_io_items.size() != 0 || io_in.valid || expected_reports.size() != 0)
      @(posedge clk_i);
    // ends still queued in the block produce no report
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_directed();
    logic [47:0] t;
    t = 48'(shadow_target);
    push_item(rlm_pkg::ACT_TICK, 1'b0, '0, '0);
    push_item(ACT_UNUSED, 1'b1, '1, WAIT_MAX);
    push_item(rlm_pkg::ACT_END, 1'b0, '1, '0);
    push_item(rlm_pkg::ACT_START, 1'b0, '0, '0);
    push_item(rlm_pkg::ACT_END, 1'b1, '0, t);
    push_item(rlm_pkg::ACT_END, 1'b0, 32'd1, t + 1);
    push_item(rlm_pkg::ACT_END, 1'b1, 32'h8000_0000, t * 10);
    push_item(rlm_pkg::ACT_END, 1'b0, 32'h7FFF_FFFF, t * 10 + 1);
    push_item(rlm_pkg::ACT_END, 1'b1, 32'h5555_5555, t * 100);
    push_item(rlm_pkg::ACT_END, 1'b0, 32'hAAAA_AAAA, t * 100 + 1);
    push_item(rlm_pkg::ACT_END, 1'b1, '1, WAIT_MAX);
    push_item(rlm_pkg::ACT_TICK, 1'b0, '0, '0);
    push_item(rlm_pkg::ACT_TICK, 1'b0, '0, '0);
    push_item(rlm_pkg::ACT_END, 1'b1, 32'd7, 48'd5);
    push_item(rlm_pkg::ACT_TICK, 1'b1, '1, WAIT_MAX);
    push_item(rlm_pkg::ACT_START, 1'b1, '1, WAIT_MAX);
    push_item(rlm_pkg::ACT_START, 1'b0, '0, '0);
    push_item(rlm_pkg::ACT_TICK, 1'b0, '0, '0);
    push_item(rlm_pkg::ACT_END, 1'b0, 32'd100, t);
    push_item(rlm_pkg::ACT_TICK, 1'b0, '0, '0);
    push_item(rlm_pkg::ACT_END, 1'b1, 32'd200, t + 1);
    push_item(rlm_pkg::ACT_TICK, 1'b0, '0, '0);
    push_item(rlm_pkg::ACT_START, 1'b0, '0, '0);
    push_item(rlm_pkg::ACT_TICK, 1'b0, '0, '0);
    push_item(rlm_pkg::ACT_END, 1'b0, 32'd3, 48'd0);
    push_item(rlm_pkg::ACT_TICK, 1'b0, '0, '0);
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = rlm_pkg::REG_TARGET;
    cfg_data_i        = '0;
    io_in.valid       = 1'b0;
    io_in.action      = rlm_pkg::ACT_START;
    io_in.direction   = 1'b0;
    io_in.byte_count  = '0;
    io_in.wait_time   = '0;
    io_rep.ready      = 1'b0;
    shadow_target = rlm_pkg::TARGET_RST;
    pps           = rlm_pkg::PPS_RST;
    track_state   = rlm_pkg::RUN_IDLE;
    in_flight     = '0;
    foreach (per_ops[i]) per_ops[i] = '0;
    foreach (per_bytes[i]) per_bytes[i] = '0;
    foreach (per_bins[i]) per_bins[i] = '0;
    foreach (hist[i]) hist[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) wait_drained();
      // phases 3 and 5 keep the target so the histograms carry over
      case (ph)
        0: begin
          write_reg(rlm_pkg::REG_TARGET, 40'd1000000);
          write_reg(rlm_pkg::REG_PPS, 40'd1);
        end
        1: begin
          write_reg(rlm_pkg::REG_TARGET, '0);
          write_reg(rlm_pkg::REG_PPS, 40'd1000000);
        end
        2: begin
          write_reg(rlm_pkg::REG_TARGET, TARGET_MAX);
          write_reg(rlm_pkg::REG_PPS, '0);
        end
        3: write_reg(rlm_pkg::REG_PPS, {20'hA5C3F, 20'hFFFFF});
        4: begin
          write_reg(rlm_pkg::REG_TARGET, 40'd1);
          write_reg(rlm_pkg::REG_PPS, 40'($urandom_range(1, 1000000)));
        end
        5: write_reg(rlm_pkg::REG_PPS, 40'({$urandom, $urandom}));
        6: begin
          write_reg(rlm_pkg::REG_TARGET, 40'({$urandom, $urandom}));
          write_reg(rlm_pkg::REG_PPS, 40'd1);
        end
        default: begin
          write_reg(rlm_pkg::REG_TARGET, 40'($urandom_range(1, 2000)));
          write_reg(rlm_pkg::REG_PPS, 40'd1000000);
        end
      endcase
      if (ph == 0) push_directed();
      repeat (ITEMS_PER_PHASE) push_random_item();
    end
    wait_drained();

    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("PASS io_rate_and_latency_monitor_unit");
    end else begin
      $display("FAIL io_rate_and_latency_monitor_unit");
    end
    $finish;
  end

endmodule
